// ===== rtl/integer_to_radix_ascii_macros.svh =====
// ---------------------------------------------------------------------------
// integer_to_radix_ascii assertion macros
// Shared property forms for the checkers of the radix conversion block.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// Same-cycle implication, disabled during reset
`define I2RA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define I2RA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2ra_pkg.sv =====
// ---------------------------------------------------------------------------
// i2ra_pkg
// Types, constants and helpers shared by the radix to ASCII converter.
// ---------------------------------------------------------------------------
package i2ra_pkg;

  localparam int VALUE_BITS = 32;
  // digit store address and division bit counter width
  localparam int DIGIT_AW   = $clog2(VALUE_BITS);
  localparam int BIT_CW     = $clog2(VALUE_BITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] DECIMAL    = 8'd10;
  localparam logic [7:0] MIN_BASE   = 8'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAW,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OSEL_RAW,
    OSEL_SIGN,
    OSEL_DIGIT
  } out_sel_t;

  typedef struct packed {
    logic     start;
    logic     div_step;
    logic     rd_en;
    logic     out_load;
    out_sel_t out_sel;
    logic     idx_dec;
  } cmd_t;

  typedef struct packed {
    logic base_zero;
    logic neg;
    logic div_done;
    logic idx_zero;
    logic out_free;
  } status_t;

  // Map a digit value to its character, wrapping modulo 256
  function automatic logic [7:0] digit_char(input logic [7:0] d);
    logic [7:0] c;
    if (d < DECIMAL) begin
      c = 8'(CHAR_ZERO + d);
    end else begin
      c = 8'(d + CHAR_A - DECIMAL);
    end
    return c;
  endfunction

endpackage

// ===== rtl/i2ra_in_if.sv =====
// ---------------------------------------------------------------------------
// i2ra_in_if
// Number request channel: selector, value bits and base.
// ---------------------------------------------------------------------------
interface i2ra_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [i2ra_pkg::VALUE_BITS-1:0]  value;
  logic [7:0]                       base;

  modport source (output valid, func, value, base, input ready);
  modport sink   (input valid, func, value, base, output ready);
endinterface

// ===== rtl/i2ra_out_if.sv =====
// ---------------------------------------------------------------------------
// i2ra_out_if
// Character channel: one ASCII code per transfer, with the final flag.
// ---------------------------------------------------------------------------
interface i2ra_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

// ===== rtl/i2ra_ram.sv =====
// ---------------------------------------------------------------------------
// i2ra_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module i2ra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/i2ra_datapath.sv =====
// ---------------------------------------------------------------------------
// i2ra_datapath
// Bit-serial divider, digit store and output register of the converter.
// ---------------------------------------------------------------------------
module i2ra_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            func,
  input  logic [i2ra_pkg::VALUE_BITS-1:0] value,
  input  logic [7:0]                      base,
  input  i2ra_pkg::cmd_t                  cmd,
  output i2ra_pkg::status_t               status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_char,
  output logic                            out_last
);

  localparam int VB = i2ra_pkg::VALUE_BITS;
  localparam int AW = i2ra_pkg::DIGIT_AW;
  localparam int CW = i2ra_pkg::BIT_CW;

  logic [VB-1:0] quot;
  logic [VB-1:0] quot_next;
  logic [7:0]    rem;
  logic [7:0]    rem_next;
  logic [7:0]    base_r;
  logic          neg;
  logic [7:0]    raw_byte;
  logic [CW-1:0] bit_cnt;
  logic [AW-1:0] digit_idx;
  logic [8:0]    trial;
  logic          take;
  logic          digit_end;
  logic          conv_done;
  logic          start_neg;
  logic [7:0]    rd_data;
  logic          idx_zero;

  // One restoring division step: bring in the next quotient bit
  always_comb begin
    trial     = {rem, quot[VB-1]};
    take      = trial >= {1'b0, base_r};
    rem_next  = take ? 8'(trial - {1'b0, base_r}) : trial[7:0];
    quot_next = {quot[VB-2:0], take};
    digit_end = bit_cnt == CW'(VB - 1);
    conv_done = digit_end && ((quot_next == '0) || (digit_idx == AW'(VB - 1)));
  end

  assign start_neg = (base == i2ra_pkg::DECIMAL) && func && value[VB-1];
  assign idx_zero  = digit_idx == '0;

  // Load the operands, then iterate the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      quot      <= '0;
      rem       <= '0;
      bit_cnt   <= '0;
      digit_idx <= '0;
      neg       <= 1'b0;
    end else if (cmd.start) begin
      quot      <= start_neg ? VB'(~value + 1'b1) : value;
      rem       <= '0;
      bit_cnt   <= '0;
      digit_idx <= '0;
      neg       <= start_neg;
    end else if (cmd.div_step) begin
      quot    <= quot_next;
      bit_cnt <= digit_end ? '0 : CW'(bit_cnt + 1'b1);
      rem     <= digit_end ? '0 : rem_next;
      if (digit_end && !conv_done) begin
        digit_idx <= AW'(digit_idx + 1'b1);
      end
    end else if (cmd.idx_dec) begin
      digit_idx <= AW'(digit_idx - 1'b1);
    end
  end

  // Hold the base and the raw byte for the whole request
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      base_r   <= (base < i2ra_pkg::MIN_BASE) ? i2ra_pkg::DECIMAL : base;
      raw_byte <= value[7:0];
    end
  end

  // Digit store, least significant digit first
  i2ra_ram #(
    .WIDTH (8),
    .DEPTH (VB)
  ) u_digit_store (
    .clk     (clk),
    .wr_en   (cmd.div_step && digit_end),
    .wr_addr (digit_idx),
    .wr_data (i2ra_pkg::digit_char(rem_next)),
    .rd_en   (cmd.rd_en),
    .rd_addr (digit_idx),
    .rd_data (rd_data)
  );

  // Output register: load a character or drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        i2ra_pkg::OSEL_RAW: begin
          out_char <= raw_byte;
          out_last <= 1'b1;
        end
        i2ra_pkg::OSEL_SIGN: begin
          out_char <= i2ra_pkg::CHAR_MINUS;
          out_last <= 1'b0;
        end
        default: begin
          out_char <= rd_data;
          out_last <= idx_zero;
        end
      endcase
    end
  end

  always_comb begin
    status.base_zero = base == '0;
    status.neg       = neg;
    status.div_done  = conv_done;
    status.idx_zero  = idx_zero;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

// ===== rtl/i2ra_ctrl.sv =====
// ---------------------------------------------------------------------------
// i2ra_ctrl
// Sequencer of the converter: accept, divide, then stream characters (or pass the raw byte).
// ---------------------------------------------------------------------------
module i2ra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2ra_pkg::status_t status,
  output i2ra_pkg::cmd_t    cmd
);

  i2ra_pkg::state_t state;
  i2ra_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2ra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      i2ra_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.base_zero ? i2ra_pkg::ST_RAW : i2ra_pkg::ST_DIV;
        end
      end
      i2ra_pkg::ST_RAW: begin
        if (status.out_free) begin
          state_next = i2ra_pkg::ST_IDLE;
        end
      end
      i2ra_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = status.neg ? i2ra_pkg::ST_SIGN : i2ra_pkg::ST_READ;
        end
      end
      i2ra_pkg::ST_SIGN: begin
        if (status.out_free) begin
          state_next = i2ra_pkg::ST_READ;
        end
      end
      i2ra_pkg::ST_READ: begin
        state_next = i2ra_pkg::ST_EMIT;
      end
      i2ra_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.idx_zero ? i2ra_pkg::ST_IDLE : i2ra_pkg::ST_READ;
        end
      end
      default: begin
        state_next = i2ra_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.div_step = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_sel  = i2ra_pkg::OSEL_DIGIT;
    cmd.idx_dec  = 1'b0;
    unique case (state)
      i2ra_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      i2ra_pkg::ST_RAW: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = i2ra_pkg::OSEL_RAW;
      end
      i2ra_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      i2ra_pkg::ST_SIGN: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = i2ra_pkg::OSEL_SIGN;
      end
      i2ra_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      i2ra_pkg::ST_EMIT: begin
        cmd.out_load = status.out_free;
        cmd.idx_dec  = status.out_free && !status.idx_zero;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/integer_to_radix_ascii.sv =====
// ---------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a binary number to ASCII digits in a chosen base.
// ---------------------------------------------------------------------------
// Usage: send one request on num (func, value, base); the characters come
// out on chars, most significant first, with last set on the final one.
// Base zero returns the raw low byte as a single character; bases below
// two act as ten; a negative signed value in base ten is led by a minus.
// Timing: a request is taken only while the sequencer is idle. Each digit
// comes from the bit-serial restoring divider, one quotient bit per cycle,
// which never stalls. Each character is then read from the digit store in
// a read state and loaded into the output register in an emit state, as
// the store's read data is registered. The last character may wait in the
// output register while the next request is already accepted.
// Reset: the sequencer returns to idle and the output register empties;
// the digit store is not cleared, since each entry is written before use.
// Stall: a character not taken is held and the sequencer waits for room.
// ---------------------------------------------------------------------------
module integer_to_radix_ascii (
  input  logic clk,
  input  logic rst,
  i2ra_in_if.sink    num,
  i2ra_out_if.source chars
);

  i2ra_pkg::cmd_t    cmd;
  i2ra_pkg::status_t status;

  // Sequencer
  i2ra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (num.valid),
    .in_ready (num.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Divider, digit store and output register
  i2ra_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .func      (num.func),
    .value     (num.value),
    .base      (num.base),
    .cmd       (cmd),
    .status    (status),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_char  (chars.char_code),
    .out_last  (chars.last)
  );

endmodule

// ===== rtl/i2ra_checker.sv =====
// ---------------------------------------------------------------------------
// i2ra_checker
// Port-level checks of the converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "integer_to_radix_ascii_macros.svh"

module i2ra_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // A stalled character stays offered
  `I2RA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "char dropped")

  // A stalled character keeps its payload
  `I2RA_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_char) && $stable(out_last), "char changed")

  // No second request right after one is taken
  `I2RA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")

  // A conversion whose final character is not out yet holds off requests
  `I2RA_ASSERT_NOW(a_busy_mid_text, clk, rst, out_valid && !out_last, !in_ready, "ready mid text")

endmodule

bind integer_to_radix_ascii i2ra_checker u_i2ra_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (num.valid),
  .in_ready  (num.ready),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .out_char  (chars.char_code),
  .out_last  (chars.last)
);

// ===== test/integer_to_radix_ascii_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_to_radix_ascii_test
// Drives number requests into the radix converter and checks every ASCII
// character against an in-bench prediction. Covers raw bytes, signed and
// unsigned decimal, base one, signed values in other bases, wrapping digits
// of large bases, random traffic with idling on both sides, and a long
// output hold-off that backs the block up into its request channel.
// ---------------------------------------------------------------------------
module integer_to_radix_ascii_test;

  localparam logic FUNC_UNSIGNED = 1'b0;
  localparam logic FUNC_SIGNED   = 1'b1;
  localparam logic [7:0] RAW_BASE = 8'd0;
  // Watchdog limit for the whole run of 120 requests
  localparam int TIMEOUT_NS = 8_000_000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } ascii_char_t;

  logic clk;
  logic rst;

  i2ra_in_if  num_if ();
  i2ra_out_if chars_if ();

  integer_to_radix_ascii u_top (
    .clk   (clk),
    .rst   (rst),
    .num   (num_if.sink),
    .chars (chars_if.source)
  );

  ascii_char_t pending_chars[$];
  int unsigned requests_seen;
  int unsigned chars_checked;
  int unsigned error_count;
  bit          no_idle;
  int          char_hold_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // Map one digit value to its character, wrapping modulo 256
  function automatic logic [7:0] ascii_digit(input logic [7:0] d);
    logic [7:0] c;
    if (d < i2ra_pkg::DECIMAL) begin
      c = i2ra_pkg::CHAR_ZERO + d;
    end else begin
      c = i2ra_pkg::CHAR_A + (d - i2ra_pkg::DECIMAL);
    end
    return c;
  endfunction

  function automatic void push_char(input logic [7:0] code, input logic last);
    ascii_char_t c;
    c.char_code = code;
    c.last      = last;
    pending_chars.push_back(c);
  endfunction

  // Queue the characters one request must produce
  function automatic void predict_conversion(input logic func, input logic [31:0] value,
                                             input logic [7:0] base);
    logic [31:0] quot;
    logic [31:0] radix;
    logic [7:0]  digits [i2ra_pkg::VALUE_BITS];
    int          ndig;
    logic        neg;
    if (base == RAW_BASE) begin
      push_char(value[7:0], 1'b1);
      return;
    end
    neg   = (base == i2ra_pkg::DECIMAL) && (func == FUNC_SIGNED) &&
            value[i2ra_pkg::VALUE_BITS-1];
    quot  = neg ? (~value + 32'd1) : value;
    radix = (base < i2ra_pkg::MIN_BASE) ? {24'd0, i2ra_pkg::DECIMAL} : {24'd0, base};
    ndig  = 0;
    do begin
      digits[ndig] = ascii_digit(8'(quot % radix));
      quot = quot / radix;
      ndig++;
    end while (quot != 32'd0 && ndig < i2ra_pkg::VALUE_BITS);
    if (neg) begin
      push_char(i2ra_pkg::CHAR_MINUS, 1'b0);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      push_char(digits[i], i == 0);
    end
  endfunction

  // Check each character, then record each accepted request
  always @(posedge clk) begin
    ascii_char_t want;
    if (!rst) begin
      if (chars_if.valid && chars_if.ready) begin
        chars_checked++;
        if (pending_chars.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $error("unexpected character 0x%02h last %0b", chars_if.char_code, chars_if.last);
        end else begin
          want = pending_chars.pop_front();
          if (chars_if.char_code !== want.char_code) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $error("char_code: expected 0x%02h, got 0x%02h", want.char_code,
                     chars_if.char_code);
          end
          if (chars_if.last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $error("last: expected %0b, got %0b", want.last, chars_if.last);
          end
        end
      end
      if (num_if.valid && num_if.ready) begin
        requests_seen++;
        predict_conversion(num_if.func, num_if.value, num_if.base);
      end
    end
  end

  // Take characters with random gaps, and hold off on request
  initial begin
    int gap;
    chars_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (char_hold_cycles > 0) begin
        chars_if.ready <= 1'b0;
        repeat (char_hold_cycles) @(posedge clk);
        char_hold_cycles = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        chars_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      chars_if.ready <= 1'b1;
      @(posedge clk);
      while (!(chars_if.valid && chars_if.ready)) @(posedge clk);
    end
  end

  // Offer one request after a random gap and wait until it is taken
  task automatic send_request(input logic func, input logic [31:0] value,
                              input logic [7:0] base);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      num_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    num_if.valid <= 1'b1;
    num_if.func  <= func;
    num_if.value <= value;
    num_if.base  <= base;
    @(posedge clk);
    while (!(num_if.valid && num_if.ready)) @(posedge clk);
  endtask

  // Drop valid and wait for the clock
  task automatic idle_requests();
    num_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_raw_byte();
    send_request(FUNC_UNSIGNED, 32'h0000_0000, RAW_BASE);
    send_request(FUNC_SIGNED,   32'hFFFF_FFFF, RAW_BASE);
    send_request(FUNC_UNSIGNED, 32'h1234_5678, RAW_BASE);
    idle_requests();
  endtask

  task automatic test_decimal();
    send_request(FUNC_UNSIGNED, 32'd0,         i2ra_pkg::DECIMAL);
    send_request(FUNC_UNSIGNED, 32'hFFFF_FFFF, i2ra_pkg::DECIMAL);
    send_request(FUNC_UNSIGNED, 32'd123,       i2ra_pkg::DECIMAL);
    send_request(FUNC_SIGNED,   32'hFFFF_FFFF, i2ra_pkg::DECIMAL);
    send_request(FUNC_SIGNED,   32'h8000_0000, i2ra_pkg::DECIMAL);
    send_request(FUNC_SIGNED,   32'h7FFF_FFFF, i2ra_pkg::DECIMAL);
    send_request(FUNC_SIGNED,   32'd0,         i2ra_pkg::DECIMAL);
    idle_requests();
  endtask

  task automatic test_base_one();
    send_request(FUNC_SIGNED,   32'hFFFF_FFFE, 8'd1);
    send_request(FUNC_UNSIGNED, 32'd42,        8'd1);
    idle_requests();
  endtask

  task automatic test_signed_other_base();
    send_request(FUNC_SIGNED, 32'hFFFF_FFFF, 8'd16);
    send_request(FUNC_SIGNED, 32'h8000_0000, 8'd2);
    send_request(FUNC_SIGNED, 32'hDEAD_BEEF, 8'd8);
    idle_requests();
  endtask

  task automatic test_large_base();
    send_request(FUNC_UNSIGNED, 32'hFFFF_FFFF, 8'd255);
    send_request(FUNC_UNSIGNED, 32'd35,        8'd36);
    send_request(FUNC_UNSIGNED, 32'd36,        8'd37);
    send_request(FUNC_SIGNED,   32'd199,       8'd200);
    send_request(FUNC_UNSIGNED, 32'd0,         8'd128);
    idle_requests();
  endtask

  // Hold the output long enough that the block stalls its request channel
  task automatic test_backpressure();
    char_hold_cycles = 600;
    no_idle = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_request(1'(i), $urandom_range(0, 255), 8'd16);
    end
    no_idle = 1'b0;
    idle_requests();
  endtask

  task automatic test_random(input int count);
    int          sel;
    int          pick;
    logic        func;
    logic [31:0] value;
    logic [7:0]  base;
    logic [31:0] corners [4];
    corners[0] = 32'h0000_0000;
    corners[1] = 32'hFFFF_FFFF;
    corners[2] = 32'h8000_0000;
    corners[3] = 32'h7FFF_FFFF;
    for (int n = 0; n < count; n++) begin
      // Run one stretch with no idling on either side
      no_idle = (n >= count / 3) && (n < count / 3 + 20);
      func = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 3);
      if (pick == 0) value = $urandom;
      else if (pick == 1) value = $urandom_range(0, 999);
      else if (pick == 2) value = corners[$urandom_range(0, 3)];
      else value = $urandom >> $urandom_range(0, 31);
      sel = $urandom_range(0, 99);
      if (sel < 30) base = i2ra_pkg::DECIMAL;
      else if (sel < 45) base = 8'(2 << ($urandom_range(0, 2) * 1)) + 8'(sel % 3 == 0) * 8'd0;
      else if (sel < 55) base = 8'($urandom_range(0, 1));
      else if (sel < 80) base = 8'($urandom_range(2, 36));
      else base = 8'($urandom_range(37, 255));
      send_request(func, value, base);
    end
    no_idle = 1'b0;
    idle_requests();
  endtask

  initial begin
    rst              <= 1'b1;
    num_if.valid     <= 1'b0;
    num_if.func      <= FUNC_UNSIGNED;
    num_if.value     <= '0;
    num_if.base      <= RAW_BASE;
    no_idle          = 1'b0;
    char_hold_cycles = 0;
    requests_seen    = 0;
    chars_checked    = 0;
    error_count      = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_raw_byte();
    test_decimal();
    test_base_one();
    test_signed_other_base();
    test_large_base();
    test_backpressure();
    test_random(94);

    // Drain, then watch for stray characters
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d requests (raw byte, signed and unsigned decimal, base one, bases 2-255)",
             requests_seen);
    $display("and %0d characters, with random idling and one long output hold-off.",
             chars_checked);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
